>>> hw/rtl/dcm_pkg.sv
// Shared types and constants for the disc carve and measure block.
// No dependencies; every other file in hw/rtl imports this package.
package dcm_pkg;

    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;
    localparam int DIM_W     = 9;                      // holds 0..MAX_COLS
    localparam int ADDR_W    = 16;
    localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int CNT_W     = 17;
    localparam int D_W       = 44;                     // signed Q27.17 offset
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_W     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_H     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_PIX_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_PIX_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd5;

    // Shared multiplier operations, setup ones in issue order
    localparam logic [3:0] MUL_NONE = 4'd0;
    localparam logic [3:0] MUL_XS   = 4'd1;
    localparam logic [3:0] MUL_XE   = 4'd2;
    localparam logic [3:0] MUL_YS   = 4'd3;
    localparam logic [3:0] MUL_YE   = 4'd4;
    localparam logic [3:0] MUL_RR   = 4'd5;
    localparam logic [3:0] MUL_BASE = 4'd6;
    localparam logic [3:0] MUL_DX   = 4'd7;
    localparam logic [3:0] MUL_DY   = 4'd8;
    localparam logic [3:0] MUL_SY   = 4'd9;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        disc_radius;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] inside_count;
        logic [CNT_W-1:0] set_count;
        logic             any_set;
    } t_out_item;

    typedef struct packed {
        logic [3:0] mul_sel;
        logic       load;
        logic       row_start;
        logic       row_next;
        logic       scan;
        logic       clear_en;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic box_empty;
        logic row_ok;
        logic x_last;
        logic y_last;
    } t_dp_stat;

endpackage

>>> hw/rtl/dcm_ctrl.sv
// Controller state machine: sequences reset clear, box setup, row and pixel scan, result handoff.
// Depends on dcm_pkg; drives dcm_dp through t_dp_cmd and reads t_dp_stat.
module dcm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  dcm_pkg::t_dp_stat i_stat,
    output dcm_pkg::t_dp_cmd  o_cmd
);
    import dcm_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_SWAIT  = 3'd3;
    localparam logic [2:0] S_ROWCHK = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_DRAIN  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       in_acc;
    logic       out_take;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    n_step     = MUL_XS;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.mul_sel = r_step;
                if (r_step == MUL_DY) begin
                    n_state = S_SWAIT;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_SWAIT: begin
                n_state = i_stat.box_empty ? S_DONE : S_ROWCHK;
            end
            S_ROWCHK: begin
                if (i_stat.row_ok) begin
                    o_cmd.mul_sel   = MUL_SY;
                    o_cmd.row_start = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.row_next = 1'b1;
                    n_state        = i_stat.y_last ? S_DRAIN : S_ROWCHK;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.x_last) begin
                    o_cmd.row_next = 1'b1;
                    n_state        = i_stat.y_last ? S_DRAIN : S_ROWCHK;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (out_take ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= MUL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hw/rtl/dcm_dp.sv
// Datapath: config registers, shared setup multiplier, pixel test pipeline, bitmap.
// Depends on dcm_pkg; commanded by dcm_ctrl.
module dcm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dcm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dcm_pkg::CFG_W-1:0]         i_cfg_data,
    input  dcm_pkg::t_in_item                 i_item,
    input  dcm_pkg::t_dp_cmd                  i_cmd,
    output dcm_pkg::t_dp_stat                 o_stat,
    output dcm_pkg::t_out_item                o_item
);
    import dcm_pkg::*;

    function automatic logic [DIM_W-1:0] clamp_lo(input logic [31:0] s,
                                                  input logic [DIM_W-1:0] lim);
        return (s > {{(32-DIM_W){1'b0}}, lim}) ? lim : s[DIM_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_hi(input logic [31:0] s,
                                                  input logic [DIM_W-1:0] lim);
        logic [32:0] e;
        e = {1'b0, s} + 33'd1;
        return (e > {{(33-DIM_W){1'b0}}, lim}) ? lim : e[DIM_W-1:0];
    endfunction

    // configuration
    logic [31:0]      r_pw, r_ph, r_iw, r_ih;
    logic [DIM_W-1:0] r_cols_cfg, r_rows_cfg;
    logic [DIM_W-1:0] cols_eff, rows_eff;

    // item
    logic             r_mode;
    logic [31:0]      r_cx, r_cy;
    logic [30:0]      r_r;
    logic [31:0]      lim;
    logic [33:0]      ax, bx, ay, by;
    logic [31:0]      ax_op, bx_op, ay_op, by_op;

    // setup multiplier
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      r_prod;
    logic [3:0]       r_psel;

    // box and scan state
    logic [DIM_W-1:0] r_xs, r_xe, r_ys, r_ye, r_x, r_y;
    logic [63:0]      r_rr, r_sy;
    logic [D_W-1:0]   r_dx0, r_dx, r_dy;
    logic [D_W-1:0]   dx_abs, dy_abs;
    logic             dx_ok;
    logic [ADDR_W-1:0] r_base, idx;

    // pixel pipeline
    logic             r_p1_v, r_p1_ok;
    logic [63:0]      r_p1_sq;
    logic [ADDR_W-1:0] r_p1_idx;
    logic             r_rd;
    logic [64:0]      d_sum;
    logic             hit;
    logic [CNT_W-1:0] r_inside, r_set;

    // bitmap
    logic             r_map [0:MAP_DEPTH-1];
    logic [ADDR_W-1:0] r_clr;
    logic             wr_en, wr_data;
    logic [ADDR_W-1:0] wr_addr;

    assign cols_eff = (r_cols_cfg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_cols_cfg;
    assign rows_eff = (r_rows_cfg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_rows_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw       <= 32'h0001_0000;
            r_ph       <= 32'h0001_0000;
            r_iw       <= 32'h0001_0000;
            r_ih       <= 32'h0001_0000;
            r_cols_cfg <= DIM_W'(MAX_COLS);
            r_rows_cfg <= DIM_W'(MAX_ROWS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIX_W:     r_pw       <= i_cfg_data;
                CFG_PIX_H:     r_ph       <= i_cfg_data;
                CFG_INV_PIX_W: r_iw       <= i_cfg_data;
                CFG_INV_PIX_H: r_ih       <= i_cfg_data;
                CFG_COLS:      r_cols_cfg <= i_cfg_data[DIM_W-1:0];
                CFG_ROWS:      r_rows_cfg <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_item.mode;
            r_cx   <= i_item.center_x;
            r_cy   <= i_item.center_y;
            r_r    <= i_item.disc_radius;
        end
    end

    // box edges along each axis: low edge only when positive, high edge when not negative
    assign lim   = {r_r, 1'b0};
    assign ax    = {{2{r_cx[31]}}, r_cx} - {3'b000, r_r};
    assign bx    = {{2{r_cx[31]}}, r_cx} + {3'b000, r_r};
    assign ay    = {{2{r_cy[31]}}, r_cy} - {3'b000, r_r};
    assign by    = {{2{r_cy[31]}}, r_cy} + {3'b000, r_r};
    assign ax_op = (!ax[33] && (ax != '0)) ? ax[31:0] : '0;
    assign bx_op = bx[33] ? '0 : bx[31:0];
    assign ay_op = (!ay[33] && (ay != '0)) ? ay[31:0] : '0;
    assign by_op = by[33] ? '0 : by[31:0];

    assign dy_abs = r_dy[D_W-1] ? (~r_dy + D_W'(1)) : r_dy;
    assign dx_abs = r_dx[D_W-1] ? (~r_dx + D_W'(1)) : r_dx;
    assign dx_ok  = (dx_abs <= {{(D_W-32){1'b0}}, lim});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_XS:   begin mul_a = ax_op; mul_b = r_iw; end
            MUL_XE:   begin mul_a = bx_op; mul_b = r_iw; end
            MUL_YS:   begin mul_a = ay_op; mul_b = r_ih; end
            MUL_YE:   begin mul_a = by_op; mul_b = r_ih; end
            MUL_RR:   begin mul_a = lim;   mul_b = lim;  end
            MUL_BASE: begin
                mul_a = {{(32-DIM_W){1'b0}}, r_ys};
                mul_b = {{(32-DIM_W){1'b0}}, cols_eff};
            end
            MUL_DX:   begin mul_a = {{(31-DIM_W){1'b0}}, r_xs, 1'b1}; mul_b = r_pw; end
            MUL_DY:   begin mul_a = {{(31-DIM_W){1'b0}}, r_ys, 1'b1}; mul_b = r_ph; end
            MUL_SY:   begin mul_a = dy_abs[31:0]; mul_b = dy_abs[31:0]; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psel <= MUL_NONE;
        end else begin
            r_psel <= i_cmd.mul_sel;
        end
    end

    // capture each product from r_prod as r_psel names it; also advance rows and columns
    always_ff @(posedge i_clk) begin
        case (r_psel)
            MUL_XS:   r_xs   <= clamp_lo(r_prod[63:32], cols_eff);
            MUL_XE:   r_xe   <= bx[33] ? '0 : clamp_hi(r_prod[63:32], cols_eff);
            MUL_YS:   r_ys   <= clamp_lo(r_prod[63:32], rows_eff);
            MUL_YE:   r_ye   <= by[33] ? '0 : clamp_hi(r_prod[63:32], rows_eff);
            MUL_RR:   r_rr   <= r_prod;
            MUL_BASE: r_base <= r_prod[ADDR_W-1:0];
            MUL_DX:   r_dx0  <= {2'b00, r_prod[41:0]} - {{11{r_cx[31]}}, r_cx, 1'b0};
            MUL_DY: begin
                r_dy <= {2'b00, r_prod[41:0]} - {{11{r_cy[31]}}, r_cy, 1'b0};
                r_y  <= r_ys;
            end
            MUL_SY:   r_sy   <= r_prod;
            default: ;
        endcase
        if (i_cmd.row_next) begin
            r_y    <= r_y + DIM_W'(1);
            r_dy   <= r_dy + {{(D_W-33){1'b0}}, r_ph, 1'b0};
            r_base <= r_base + {{(ADDR_W-DIM_W){1'b0}}, cols_eff};
        end
        if (i_cmd.row_start) begin
            r_x  <= r_xs;
            r_dx <= r_dx0;
        end else if (i_cmd.scan) begin
            r_x  <= r_x + DIM_W'(1);
            r_dx <= r_dx + {{(D_W-33){1'b0}}, r_pw, 1'b0};
        end
    end

    assign idx = r_base + {{(ADDR_W-DIM_W+1){1'b0}}, r_x[DIM_W-2:0]};

    // pixel stage one: column test, square, bitmap read
    always_ff @(posedge i_clk) begin
        r_p1_ok  <= dx_ok;
        r_p1_sq  <= dx_ok ? (dx_abs[31:0] * dx_abs[31:0]) : '0;
        r_p1_idx <= idx;
    end

    // pixel stage two: disc test and counting
    assign d_sum = {1'b0, r_p1_sq} + {1'b0, r_sy};
    assign hit   = r_p1_v && r_p1_ok && (d_sum <= {1'b0, r_rr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v   <= 1'b0;
            r_inside <= '0;
            r_set    <= '0;
            r_clr    <= '0;
        end else begin
            r_p1_v <= i_cmd.scan;
            if (i_cmd.load) begin
                r_inside <= '0;
                r_set    <= '0;
            end else if (hit) begin
                r_inside <= r_inside + CNT_W'(1);
                if (r_rd) begin
                    r_set <= r_set + CNT_W'(1);
                end
            end
            if (i_cmd.clear_en) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
        end
    end

    assign wr_en   = i_cmd.clear_en || (hit && r_mode);
    assign wr_addr = i_cmd.clear_en ? r_clr : r_p1_idx;
    assign wr_data = i_cmd.clear_en;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        r_rd <= r_map[idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_item.inside_count <= r_inside;
            o_item.set_count    <= r_set;
            o_item.any_set      <= (r_set != '0);
        end
    end

    assign o_stat.clear_done = (r_clr == '1);
    assign o_stat.box_empty  = (r_xs >= r_xe) || (r_ys >= r_ye);
    assign o_stat.row_ok     = (dy_abs <= {{(D_W-32){1'b0}}, lim});
    assign o_stat.x_last     = ((r_x + DIM_W'(1)) == r_xe);
    assign o_stat.y_last     = ((r_y + DIM_W'(1)) == r_ye);

endmodule

>>> hw/rtl/disc_carve_and_measure_bitmap.sv
// Top level of the disc carve and measure block: controller plus datapath.
// Depends on dcm_pkg, dcm_ctrl and dcm_dp.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------
//   in      | input     | i_in_valid/o_in_stall | i_in_item  (t_in_item)
//   out     | output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
//   cfg     | input     | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// Sequence: an accepted item gets box setup (eight issues on the shared multiplier
// and a wait for the last product), then each row that misses the disc is skipped,
// each row that crosses it is scanned across the box width, and the pixel pipeline
// drains before the result loads; an empty box goes straight to the load.
// The bitmap is read at one pixel per cycle while a row is scanned.
// Reset: synchronous, active low; after it the block sweeps the 65536-bit
// bitmap to all ones, one bit a cycle, holding o_in_stall high throughout.
// Stalls: a finished result waits in the output register while the next
// transfer is taken; a new result loads only once that register is free.
module disc_carve_and_measure_bitmap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dcm_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dcm_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [dcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dcm_pkg::CFG_W-1:0]     i_cfg_data
);
    import dcm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequence clear, setup, scan and result handoff
    dcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // hold config, bitmap, box math and the pixel pipeline
    dcm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_item     (o_out_item)
    );

endmodule
